### design/bbt_pkg.sv
// Package for the border background trim block: word types, register
// indexes and fixed sizes. No dependencies.
package bbt_pkg;

    // Count fields are fixed at 13 bits
    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_FIELD_MAX = 13'd8191;

    // Queue between classifier and counter
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_LW    = 3;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic REG_BACKGROUND_RGB = 1'b0;
    localparam logic REG_MATCH_LIMIT    = 1'b1;

    localparam logic [23:0] BACKGROUND_RESET  = 24'd0;
    localparam logic [17:0] MATCH_LIMIT_RESET = 18'd4064;

    // Input word: one pixel
    typedef struct packed {
        logic [23:0] pixel_rgb;
        logic [7:0]  pixel_alpha;
        logic        last_in_row;
    } pixel_word_t;

    // Result word: counts for one row
    typedef struct packed {
        logic [COUNT_W-1:0] leading_clear_count;
        logic [COUNT_W-1:0] trailing_clear_count;
    } result_word_t;

    // Classified pixel passed from front to back
    typedef struct packed {
        logic is_match;
        logic alpha_nz;
        logic last;
    } class_word_t;

    // Queue status seen by the front end
    typedef struct packed {
        logic [QUEUE_LW-1:0] level;
        logic                not_empty;
    } queue_status_t;

endpackage

### design/bbt_front.sv
// Front end: accepts pixels, squares the channel differences, compares the
// sum with the match limit and pushes a class word. Depends on bbt_pkg.
module bbt_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  bbt_pkg::pixel_word_t  pix_word,
    input  logic [23:0]           background_rgb,
    input  logic [17:0]           match_limit,
    input  bbt_pkg::queue_status_t q_status,
    output logic                  push,
    output bbt_pkg::class_word_t  push_word
);

    logic                        s1_valid_reg;
    logic [15:0]                 sq_r_reg, sq_g_reg, sq_b_reg;
    logic                        s1_alpha_nz_reg;
    logic                        s1_last_reg;
    logic                        accept;
    logic [7:0]                  d_r, d_g, d_b;
    logic [17:0]                 sum;
    logic [bbt_pkg::QUEUE_LW:0]  need;

    // Stall when the queue could not hold this word and the one in flight
    assign need      = {1'b0, q_status.level} + {{bbt_pkg::QUEUE_LW{1'b0}}, s1_valid_reg};
    assign pix_stall = (need >= (bbt_pkg::QUEUE_LW + 1)'(bbt_pkg::QUEUE_DEPTH));
    assign accept    = pix_valid && !pix_stall;

    // Absolute channel differences
    always_comb
    begin
        d_r = (pix_word.pixel_rgb[23:16] > background_rgb[23:16])
            ? pix_word.pixel_rgb[23:16] - background_rgb[23:16]
            : background_rgb[23:16] - pix_word.pixel_rgb[23:16];
        d_g = (pix_word.pixel_rgb[15:8] > background_rgb[15:8])
            ? pix_word.pixel_rgb[15:8] - background_rgb[15:8]
            : background_rgb[15:8] - pix_word.pixel_rgb[15:8];
        d_b = (pix_word.pixel_rgb[7:0] > background_rgb[7:0])
            ? pix_word.pixel_rgb[7:0] - background_rgb[7:0]
            : background_rgb[7:0] - pix_word.pixel_rgb[7:0];
    end

    // Square stage: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // Square stage: payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_r_reg        <= {8'd0, d_r} * {8'd0, d_r};
            sq_g_reg        <= {8'd0, d_g} * {8'd0, d_g};
            sq_b_reg        <= {8'd0, d_b} * {8'd0, d_b};
            s1_alpha_nz_reg <= (pix_word.pixel_alpha != 8'd0);
            s1_last_reg     <= pix_word.last_in_row;
        end
    end

    // Sum and compare, straight into the queue
    assign sum                = {2'b00, sq_r_reg} + {2'b00, sq_g_reg} + {2'b00, sq_b_reg};
    assign push               = s1_valid_reg;
    assign push_word.is_match = (sum <= match_limit);
    assign push_word.alpha_nz = s1_alpha_nz_reg;
    assign push_word.last     = s1_last_reg;

endmodule

### design/bbt_queue.sv
// Short queue of class words between front and back end.
// Depends on bbt_pkg.
module bbt_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bbt_pkg::class_word_t   push_word,
    input  logic                   pop,
    output bbt_pkg::class_word_t   head_word,
    output bbt_pkg::queue_status_t status
);

    bbt_pkg::class_word_t              entry_reg [bbt_pkg::QUEUE_DEPTH];
    logic [bbt_pkg::QUEUE_AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [bbt_pkg::QUEUE_LW-1:0]      level_reg, level_next;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    // Level tracking
    always_comb
    begin
        level_next = level_reg;
        case ({push, pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

    assign head_word        = entry_reg[rd_ptr_reg];
    assign status.level     = level_reg;
    assign status.not_empty = (level_reg != '0);

endmodule

### design/bbt_back.sv
// Back end: runs the leading and trailing run counters over class words
// and loads the result register at row end. Depends on bbt_pkg.
module bbt_back
#(
    parameter logic [bbt_pkg::COUNT_W-1:0] COUNT_CAP = 13'd4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bbt_pkg::queue_status_t q_status,
    input  bbt_pkg::class_word_t   head_word,
    output logic                   pop,
    output logic                   res_valid,
    input  logic                   res_stall,
    output bbt_pkg::result_word_t  res_word
);

    logic                          lead_active_reg, lead_active_next;
    logic [bbt_pkg::COUNT_W-1:0]   lead_count_reg, lead_count_next;
    logic [bbt_pkg::COUNT_W-1:0]   trail_run_reg, trail_run_next;
    logic                          res_valid_reg;
    bbt_pkg::result_word_t         res_word_reg;
    logic                          lead_hit;
    logic                          load;

    // Pop unless a row end would overwrite a result still waiting
    assign pop  = q_status.not_empty &&
                  (!head_word.last || !res_valid_reg || !res_stall);
    assign load = pop && head_word.last;

    // Run counter update
    always_comb
    begin
        lead_hit         = lead_active_reg && head_word.is_match;
        lead_active_next = lead_hit;
        lead_count_next  = lead_count_reg;
        trail_run_next   = '0;
        if (lead_hit)
        begin
            lead_count_next = (lead_count_reg < COUNT_CAP)
                            ? lead_count_reg + 1'b1 : COUNT_CAP;
        end
        else if (head_word.is_match && head_word.alpha_nz)
        begin
            trail_run_next = (trail_run_reg < COUNT_CAP)
                           ? trail_run_reg + 1'b1 : COUNT_CAP;
        end
    end

    // Row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_active_reg <= 1'b1;
            lead_count_reg  <= '0;
            trail_run_reg   <= '0;
        end
        else if (pop)
        begin
            if (head_word.last)
            begin
                lead_active_reg <= 1'b1;
                lead_count_reg  <= '0;
                trail_run_reg   <= '0;
            end
            else
            begin
                lead_active_reg <= lead_active_next;
                lead_count_reg  <= lead_count_next;
                trail_run_reg   <= trail_run_next;
            end
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_word_reg.leading_clear_count  <= lead_count_next;
            res_word_reg.trailing_clear_count <= trail_run_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

### design/border_background_trim_top.sv
// Border background trim, top level: config registers, front end, queue
// and back end. Depends on bbt_pkg, bbt_front, bbt_queue, bbt_back.
//
// Takes pixel words and gives one result word per row, on the pixel marked
// last in row, holding the leading and trailing background run lengths.
// Throughput is one pixel per clock while nothing stalls; the front end
// registers the channel squares and compares their sum on the way into the
// queue, and the back end counter takes one class word per clock unless a
// row end meets a waiting stalled result, and it registers each row result.
// The four-entry queue absorbs a stalled result side for a few pixels;
// pixel intake stalls once the queue fills. Both counts saturate at the
// smaller of MAX_WIDTH and 8191. Registers: background_rgb at byte address
// 0, match_limit at 4; write them only while idle.
module border_background_trim_top
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  bbt_pkg::pixel_word_t  pix_word,
    output logic                  res_valid,
    input  logic                  res_stall,
    output bbt_pkg::result_word_t res_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [bbt_pkg::COUNT_W-1:0] CountCap =
        (MAX_WIDTH < int'(bbt_pkg::COUNT_FIELD_MAX))
        ? bbt_pkg::COUNT_W'(MAX_WIDTH) : bbt_pkg::COUNT_FIELD_MAX;

    logic [23:0]             background_rgb_reg;
    logic [17:0]             match_limit_reg;
    logic                    cfg_write;
    logic                    push, pop;
    bbt_pkg::class_word_t    push_word, head_word;
    bbt_pkg::queue_status_t  q_status;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            background_rgb_reg <= bbt_pkg::BACKGROUND_RESET;
            match_limit_reg    <= bbt_pkg::MATCH_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                bbt_pkg::REG_BACKGROUND_RGB: background_rgb_reg <= pwdata[23:0];
                bbt_pkg::REG_MATCH_LIMIT:    match_limit_reg    <= pwdata[17:0];
                default:                     match_limit_reg    <= match_limit_reg;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        case (paddr[2])
            bbt_pkg::REG_BACKGROUND_RGB: prdata = {8'd0, background_rgb_reg};
            bbt_pkg::REG_MATCH_LIMIT:    prdata = {14'd0, match_limit_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    bbt_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .pix_word       (pix_word),
        .background_rgb (background_rgb_reg),
        .match_limit    (match_limit_reg),
        .q_status       (q_status),
        .push           (push),
        .push_word      (push_word)
    );

    bbt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .status    (q_status)
    );

    bbt_back #(
        .COUNT_CAP (CountCap)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_word (head_word),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

### design/bbt_checker.sv
// Port-level checks for the border background trim block, and the bind
// that attaches them to the top level. Depends on bbt_pkg.
module bbt_checker
#(
    parameter int MAX_WIDTH = 4096
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  res_valid,
    input logic                  res_stall,
    input bbt_pkg::result_word_t res_word
);

    localparam logic [bbt_pkg::COUNT_W-1:0] CountCap =
        (MAX_WIDTH < int'(bbt_pkg::COUNT_FIELD_MAX))
        ? bbt_pkg::COUNT_W'(MAX_WIDTH) : bbt_pkg::COUNT_FIELD_MAX;

    // A stalled result word stays
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result word dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_word))
        else $error("result word changed while stalled");

    // Counts never pass the saturation cap
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_word.leading_clear_count <= CountCap) &&
                      (res_word.trailing_clear_count <= CountCap))
        else $error("count above saturation cap");

    // No result right out of reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid out of reset");

endmodule

bind border_background_trim_top bbt_checker #(.MAX_WIDTH(MAX_WIDTH)) u_bbt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
);

### test/tb.sv
// Testbench for border_background_trim_top: random and directed pixel rows,
// checked row by row against a built-in run-length predictor.
// Depends on bbt_pkg and the border_background_trim_top RTL.
module tb;

    localparam int MAX_WIDTH = 4096;
    localparam int ROW_CAP   = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
    localparam int RAND_PER_SEG = 85;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pix_valid = 1'b0;
    logic        pix_stall;
    bbt_pkg::pixel_word_t pix_word = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    bbt_pkg::result_word_t res_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // stimulus and scoreboard storage
    bbt_pkg::pixel_word_t  pixel_queue[$];
    bbt_pkg::result_word_t row_counts_q[$];
    bit           pix_taken = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           mismatches = 0;
    int           pixels_taken = 0;
    int           rows_checked = 0;
    int           settings_used = 1;

    // predictor copy of registers and row state
    logic [23:0]  bg_rgb = bbt_pkg::BACKGROUND_RESET;
    logic [17:0]  limit_reg = bbt_pkg::MATCH_LIMIT_RESET;
    bit           lead_active = 1'b1;
    int           lead_run = 0;
    int           trail_run = 0;

    border_background_trim_top #(.MAX_WIDTH(MAX_WIDTH)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix_word(pix_word),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_word(res_word),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic bit is_background_px(logic [23:0] rgb);
        int sum;
        int d;
        sum = 0;
        for (int c = 0; c < 3; c++)
        begin
            d = int'(rgb[8*c +: 8]) - int'(bg_rgb[8*c +: 8]);
            sum += d * d;
        end
        return sum <= int'(limit_reg);
    endfunction

    function automatic int bump(int v);
        return (v < ROW_CAP) ? v + 1 : ROW_CAP;
    endfunction

    // Update run lengths for one accepted pixel; queue counts at row end
    function automatic void track_pixel(bbt_pkg::pixel_word_t w);
        bbt_pkg::result_word_t r;
        bit hit;
        hit = is_background_px(w.pixel_rgb);
        if (lead_active && hit)
        begin
            lead_run = bump(lead_run);
            trail_run = 0;
        end
        else
        begin
            lead_active = 1'b0;
            trail_run = (hit && w.pixel_alpha != 8'd0) ? bump(trail_run) : 0;
        end
        if (w.last_in_row)
        begin
            r.leading_clear_count = lead_run[bbt_pkg::COUNT_W-1:0];
            r.trailing_clear_count = trail_run[bbt_pkg::COUNT_W-1:0];
            row_counts_q.insert(row_counts_q.size(), r);
            lead_active = 1'b1;
            lead_run = 0;
            trail_run = 0;
        end
    endfunction

    function automatic void add_pixel(logic [23:0] rgb, logic [7:0] alpha, bit last);
        bbt_pkg::pixel_word_t w;
        w.pixel_rgb = rgb;
        w.pixel_alpha = alpha;
        w.last_in_row = last;
        pixel_queue.insert(pixel_queue.size(), w);
    endfunction

    // Colour within +-40 per channel of the background, clamped
    function automatic logic [23:0] near_background();
        logic [23:0] rgb;
        int v;
        for (int c = 0; c < 3; c++)
        begin
            v = int'(bg_rgb[8*c +: 8]) + int'($urandom_range(80)) - 40;
            v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
            rgb[8*c +: 8] = v[7:0];
        end
        return rgb;
    endfunction

    function automatic logic [23:0] pick_rgb(bit lead_zone);
        int r;
        r = $urandom_range(99);
        if (lead_zone)
            return (r < 40) ? bg_rgb : near_background();
        if (r < 35)
            return 24'($urandom_range(24'hFFFFFF));
        if (r < 55)
            return bg_rgb;
        return near_background();
    endfunction

    function automatic logic [7:0] pick_alpha();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return 8'd0;
        if (r < 20)
            return 8'd255;
        return 8'($urandom_range(254, 1));
    endfunction

    // Mostly background-led rows of random length with random content
    function automatic int add_random_rows(int target);
        int count;
        int len;
        int lead_len;
        count = 0;
        while (count < target)
        begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(20, 2);
            lead_len = $urandom_range(len);
            for (int i = 0; i < len; i++)
                add_pixel(pick_rgb(i < lead_len), pick_alpha(), i == len - 1);
            count += len;
        end
        return count;
    endfunction

    // Write a register, then read it back through the same port
    task automatic write_register(input logic idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] want;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == bbt_pkg::REG_BACKGROUND_RGB)
            bg_rgb = value[23:0];
        else
            limit_reg = value[17:0];
        want = (idx == bbt_pkg::REG_BACKGROUND_RGB) ? {8'd0, bg_rgb} : {14'd0, limit_reg};
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== want)
            report_mismatch($sformatf("register %0d read %h, wrote %h", idx, readback, want));
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pixel_queue.size() != 0 || pix_valid || row_counts_q.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    // Pixel driver and result-side stall, changed on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_taken)
                ;   // hold the stalled word
            else if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pix_word <= pixel_queue.pop_front();
                pix_valid <= 1'b1;
            end
            else
                pix_valid <= 1'b0;
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predict on accepted pixels, check accepted results
    always @(posedge clk)
    begin
        bbt_pkg::result_word_t want;
        pix_taken = pix_valid && !pix_stall;
        if (rst_n)
        begin
            if (pix_taken)
            begin
                pixels_taken++;
                track_pixel(pix_word);
            end
            if (res_valid && !res_stall)
            begin
                rows_checked++;
                if (row_counts_q.size() == 0)
                    report_mismatch("result word with no row pending");
                else
                begin
                    want = row_counts_q.pop_front();
                    if (res_word.leading_clear_count !== want.leading_clear_count)
                        report_mismatch($sformatf("row %0d leading %0d, want %0d",
                            rows_checked, res_word.leading_clear_count,
                            want.leading_clear_count));
                    if (res_word.trailing_clear_count !== want.trailing_clear_count)
                        report_mismatch($sformatf("row %0d trailing %0d, want %0d",
                            rows_checked, res_word.trailing_clear_count,
                            want.trailing_clear_count));
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Segment 0: reset settings, directed rows, sender idles 35, receiver 74
        send_idle_pct = 35;
        recv_stall_pct = 74;
        add_pixel(24'h000000, 8'd255, 1'b1);            // one-pixel background row
        add_pixel(24'hFFFFFF, 8'd0, 1'b1);              // one-pixel foreground row
        add_pixel({8'd60, 8'd20, 8'd8}, 8'd1, 1'b0);    // distance exactly at limit
        add_pixel({8'd60, 8'd20, 8'd9}, 8'd255, 1'b0);  // above the limit
        add_pixel(24'h000000, 8'h80, 1'b0);
        add_pixel(24'h000000, 8'd0, 1'b0);
        add_pixel(24'h000000, 8'd7, 1'b0);
        add_pixel({8'd60, 8'd20, 8'd8}, 8'd255, 1'b1);
        add_pixel(24'h000000, 8'd0, 1'b0);              // fully background row
        add_pixel(24'h000000, 8'd0, 1'b0);
        add_pixel(24'h000000, 8'd255, 1'b1);
        add_pixel(24'hFFFFFF, 8'd255, 1'b0);            // trailing run of three
        add_pixel(24'h00FF00, 8'd255, 1'b0);
        add_pixel(24'h000000, 8'd1, 1'b0);
        add_pixel(24'h000000, 8'd1, 1'b0);
        add_pixel(24'h010101, 8'd255, 1'b1);
        add_pixel(24'h123456, 8'd255, 1'b0);            // trailing run cut by alpha zero
        add_pixel(24'h000000, 8'd255, 1'b0);
        add_pixel(24'h000000, 8'd0, 1'b1);
        void'(add_random_rows(RAND_PER_SEG - 19));
        wait_drained();

        // Segment 1: white background, exact match only
        write_register(bbt_pkg::REG_BACKGROUND_RGB, 32'h00FF_FFFF);
        write_register(bbt_pkg::REG_MATCH_LIMIT, 32'd0);
        settings_used++;
        void'(add_random_rows(RAND_PER_SEG));
        wait_drained();

        // Segment 2: roles swapped, everything matches
        send_idle_pct = 74;
        recv_stall_pct = 35;
        write_register(bbt_pkg::REG_BACKGROUND_RGB, $urandom);
        write_register(bbt_pkg::REG_MATCH_LIMIT, 32'h0003_FFFF);
        settings_used++;
        void'(add_random_rows(RAND_PER_SEG));
        wait_drained();

        // Segment 3: random background and moderate limit
        write_register(bbt_pkg::REG_BACKGROUND_RGB, $urandom);
        write_register(bbt_pkg::REG_MATCH_LIMIT, $urandom_range(30000));
        settings_used++;
        void'(add_random_rows(RAND_PER_SEG));
        wait_drained();

        // Segment 4: no idling, gray background, longer full and trailing rows
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_register(bbt_pkg::REG_BACKGROUND_RGB, 32'h0080_8080);
        write_register(bbt_pkg::REG_MATCH_LIMIT, 32'd4064);
        settings_used++;
        for (int i = 0; i < 20; i++)
            add_pixel(bg_rgb, pick_alpha(), i == 19);
        add_pixel(24'h000000, 8'd255, 1'b0);
        for (int i = 0; i < 20; i++)
            add_pixel(bg_rgb, 8'($urandom_range(255, 1)), i == 19);
        void'(add_random_rows(RAND_PER_SEG - 41));
        wait_drained();

        // Segment 5: black background, largest in-range limit
        write_register(bbt_pkg::REG_BACKGROUND_RGB, 32'd0);
        write_register(bbt_pkg::REG_MATCH_LIMIT, 32'd195075);
        settings_used++;
        void'(add_random_rows(RAND_PER_SEG));
        wait_drained();

        $display("Checked %0d rows from %0d pixels over %0d register settings.",
                 rows_checked, pixels_taken, settings_used);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
design/bbt_pkg.sv
design/bbt_front.sv
design/bbt_queue.sv
design/bbt_back.sv
design/border_background_trim_top.sv
design/bbt_checker.sv
test/tb.sv
